/* rtl/pmt_pkg.sv */
`default_nettype none

package pmt_pkg;

  localparam int POS_BITS  = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int DELTA_W   = 9;
  localparam int SUM_W     = ((POS_BITS > CFG_W) ? POS_BITS : CFG_W) + 2;

  localparam logic [POS_BITS-1:0] POS_MASK = {POS_BITS{1'b1}};

  localparam logic [CFG_W-1:0] MAX_X_RESET = CFG_W'(1920);
  localparam logic [CFG_W-1:0] MAX_Y_RESET = CFG_W'(1080);

  localparam int HDR_SYNC_BIT  = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DX   = 2'd1,
    PH_DY   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    MK_NONE = 2'd0,
    MK_MOVE = 2'd1,
    MK_DRAG = 2'd2
  } motion_t;

  // add a signed delta and clamp to [0, min(top, POS_MASK)]
  function automatic logic [POS_BITS-1:0] move_clamp(
    input logic [POS_BITS-1:0]       pos,
    input logic signed [DELTA_W-1:0] delta,
    input logic [CFG_W-1:0]          top
  );
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] lim;
    logic signed [SUM_W-1:0] top_w;
    logic signed [SUM_W-1:0] mask_w;
    logic signed [SUM_W-1:0] res;
    s      = $signed({{(SUM_W-POS_BITS){1'b0}}, pos}) + SUM_W'(delta);
    top_w  = $signed({{(SUM_W-CFG_W){1'b0}}, top});
    mask_w = $signed({{(SUM_W-POS_BITS){1'b0}}, POS_MASK});
    lim    = (top_w > mask_w) ? mask_w : top_w;
    res    = s;
    if (s < 0) res = '0;
    else if (s > lim) res = lim;
    return res[POS_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/ps2_mouse_packet_tracker_top.sv */
// an input transfer reaches out_valid through the input register, then
//   decode/add/clamp into the result register
// throughput: one byte per cycle; a stalled result holds the input register
// every third byte of a packet gives one result, dropped header bytes give none
// reset (rst_n low, synchronous): hunting for a header, cursor and buttons zero,
//   max_x = 1920, max_y = 1080, pipeline empty
`default_nettype none

module ps2_mouse_packet_tracker_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_rx_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [pmt_pkg::POS_BITS-1:0]           out_pos_x,
  output logic [pmt_pkg::POS_BITS-1:0]           out_pos_y,
  output logic [1:0]                             out_button_bits,
  output logic signed [pmt_pkg::DELTA_W-1:0]     out_delta_x,
  output logic signed [pmt_pkg::DELTA_W-1:0]     out_delta_y,
  output logic                                   out_click,
  output logic [1:0]                             out_motion_kind,
  input  wire logic                              cfg_we,
  input  wire logic [pmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pmt_pkg::CFG_W-1:0]         cfg_wdata
);

  logic [pmt_pkg::CFG_W-1:0] max_x_r;
  logic [pmt_pkg::CFG_W-1:0] max_y_r;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  pmt_pkg::phase_t             phase_r, phase_nxt;
  logic [7:0]                  header_r, header_nxt;
  logic [7:0]                  dx_hold_r, dx_hold_nxt;
  logic [pmt_pkg::POS_BITS-1:0] cur_x_r, cur_x_nxt;
  logic [pmt_pkg::POS_BITS-1:0] cur_y_r, cur_y_nxt;
  logic [1:0]                  prev_btn_r, prev_btn_nxt;

  logic                                 res_valid_nxt;
  logic signed [pmt_pkg::DELTA_W-1:0]   dx, dy;
  logic [1:0]                           btn;
  logic                                 click;
  pmt_pkg::motion_t                     kind;

  logic out_free;
  logic s1_go;

  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r <= pmt_pkg::MAX_X_RESET;
      max_y_r <= pmt_pkg::MAX_Y_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pmt_pkg::CFG_MAX_X: max_x_r <= cfg_wdata;
        pmt_pkg::CFG_MAX_Y: max_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // decode, accumulate and clamp
  always_comb begin
    phase_nxt     = phase_r;
    header_nxt    = header_r;
    dx_hold_nxt   = dx_hold_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    prev_btn_nxt  = prev_btn_r;
    res_valid_nxt = 1'b0;

    dx    = $signed({header_r[pmt_pkg::HDR_XSIGN_BIT], dx_hold_r});
    dy    = $signed({header_r[pmt_pkg::HDR_YSIGN_BIT], s1_byte_r});
    btn   = header_r[1:0];
    click = (prev_btn_r == 2'd0) && (btn != 2'd0);
    if (dx == '0 && dy == '0) kind = pmt_pkg::MK_NONE;
    else if (btn != 2'd0)     kind = pmt_pkg::MK_DRAG;
    else                      kind = pmt_pkg::MK_MOVE;

    if (s1_go) begin
      case (phase_r)
        pmt_pkg::PH_DX: begin
          dx_hold_nxt = s1_byte_r;
          phase_nxt   = pmt_pkg::PH_DY;
        end
        pmt_pkg::PH_DY: begin
          phase_nxt     = pmt_pkg::PH_HUNT;
          cur_x_nxt     = pmt_pkg::move_clamp(cur_x_r, dx, max_x_r);
          cur_y_nxt     = pmt_pkg::move_clamp(cur_y_r, dy, max_y_r);
          prev_btn_nxt  = btn;
          res_valid_nxt = 1'b1;
        end
        default: begin
          // hunting: only a byte with the sync bit starts a packet
          if (s1_byte_r[pmt_pkg::HDR_SYNC_BIT]) begin
            header_nxt = s1_byte_r;
            phase_nxt  = pmt_pkg::PH_DX;
          end else begin
            phase_nxt  = pmt_pkg::PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= pmt_pkg::PH_HUNT;
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      prev_btn_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      prev_btn_r <= prev_btn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    header_r  <= header_nxt;
    dx_hold_r <= dx_hold_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid_nxt) begin
      out_pos_x       <= cur_x_nxt;
      out_pos_y       <= cur_y_nxt;
      out_button_bits <= btn;
      out_delta_x     <= dx;
      out_delta_y     <= dy;
      out_click       <= click;
      out_motion_kind <= kind;
    end
  end

endmodule

`default_nettype wire

/* rtl/pmt_checker.sv */
`default_nettype none

module pmt_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [1:0]                        out_button_bits,
  input wire logic signed [pmt_pkg::DELTA_W-1:0] out_delta_x,
  input wire logic signed [pmt_pkg::DELTA_W-1:0] out_delta_y,
  input wire logic                              out_click,
  input wire logic [1:0]                        out_motion_kind
);

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motion_kind == pmt_pkg::MK_NONE |->
      out_delta_x == '0 && out_delta_y == '0)
    else $error("no-motion kind with nonzero delta");

  a_drag_buttons: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motion_kind == pmt_pkg::MK_DRAG |-> out_button_bits != 2'd0)
    else $error("drag without a button");

  a_click_buttons: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_click |-> out_button_bits != 2'd0)
    else $error("click without a button");

endmodule

bind ps2_mouse_packet_tracker_top pmt_checker u_pmt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_button_bits (out_button_bits),
  .out_delta_x     (out_delta_x),
  .out_delta_y     (out_delta_y),
  .out_click       (out_click),
  .out_motion_kind (out_motion_kind)
);

`default_nettype wire

/* tb/mouse_report_checker.sv */
module mouse_report_checker
  import pmt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [7:0]                 in_rx_byte,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [POS_BITS-1:0]        out_pos_x,
  input  logic [POS_BITS-1:0]        out_pos_y,
  input  logic [1:0]                 out_button_bits,
  input  logic signed [DELTA_W-1:0]  out_delta_x,
  input  logic signed [DELTA_W-1:0]  out_delta_y,
  input  logic                       out_click,
  input  logic [1:0]                 out_motion_kind,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  output int                         err_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [POS_BITS-1:0]       pos_x;
    logic [POS_BITS-1:0]       pos_y;
    logic [1:0]                buttons;
    logic signed [DELTA_W-1:0] dlt_x;
    logic signed [DELTA_W-1:0] dlt_y;
    logic                      click;
    motion_t                   kind;
  } packet_report_t;

  packet_report_t reports_due[$];
  packet_report_t got;
  packet_report_t want;

  // predicted decoder state and limits
  phase_t              phase;
  logic [7:0]          hdr;
  logic [7:0]          dx_raw;
  logic [POS_BITS-1:0] cur_x;
  logic [POS_BITS-1:0] cur_y;
  logic [1:0]          last_btn;
  logic [CFG_W-1:0]    lim_x;
  logic [CFG_W-1:0]    lim_y;
  int                  errs = 0;

  function automatic logic [POS_BITS-1:0] clamp_axis(input logic [POS_BITS-1:0] pos,
                                                     input int step,
                                                     input logic [CFG_W-1:0] top);
    int ceiling;
    int sum;
    ceiling = (int'(top) > int'(POS_MASK)) ? int'(POS_MASK) : int'(top);
    sum = int'(pos) + step;
    if (sum < 0) sum = 0;
    if (sum > ceiling) sum = ceiling;
    return sum[POS_BITS-1:0];
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic signed [DELTA_W-1:0] sx;
    logic signed [DELTA_W-1:0] sy;
    int step_x;
    int step_y;
    packet_report_t r;
    case (phase)
      PH_DX: begin
        dx_raw = b;
        phase = PH_DY;
      end
      PH_DY: begin
        sx = {hdr[HDR_XSIGN_BIT], dx_raw};
        sy = {hdr[HDR_YSIGN_BIT], b};
        step_x = sx;
        step_y = sy;
        cur_x = clamp_axis(cur_x, step_x, lim_x);
        cur_y = clamp_axis(cur_y, step_y, lim_y);
        r.pos_x = cur_x;
        r.pos_y = cur_y;
        r.buttons = hdr[1:0];
        r.dlt_x = sx;
        r.dlt_y = sy;
        r.click = (last_btn == 2'b00) && (hdr[1:0] != 2'b00);
        if (step_x == 0 && step_y == 0) r.kind = MK_NONE;
        else if (hdr[1:0] != 2'b00) r.kind = MK_DRAG;
        else r.kind = MK_MOVE;
        last_btn = hdr[1:0];
        reports_due.push_back(r);
        phase = PH_HUNT;
      end
      default: begin
        // hunting: only a byte with the sync bit starts a packet
        if (b[HDR_SYNC_BIT]) begin
          hdr = b;
          phase = PH_DX;
        end else begin
          phase = PH_HUNT;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase = PH_HUNT;
      hdr = '0;
      dx_raw = '0;
      cur_x = '0;
      cur_y = '0;
      last_btn = '0;
      lim_x = MAX_X_RESET;
      lim_y = MAX_Y_RESET;
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_X: lim_x = cfg_wdata;
          CFG_MAX_Y: lim_y = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.pos_x = out_pos_x;
        got.pos_y = out_pos_y;
        got.buttons = out_button_bits;
        got.dlt_x = out_delta_x;
        got.dlt_y = out_delta_y;
        got.click = out_click;
        got.kind = motion_t'(out_motion_kind);
        if (reports_due.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%t unexpected result x=%0d y=%0d btn=%0d dx=%0d dy=%0d click=%0d kind=%0d",
                     $realtime, got.pos_x, got.pos_y, got.buttons, got.dlt_x, got.dlt_y,
                     got.click, got.kind);
        end else begin
          want = reports_due.pop_front();
          if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
              got.buttons !== want.buttons || got.dlt_x !== want.dlt_x ||
              got.dlt_y !== want.dlt_y || got.click !== want.click ||
              got.kind !== want.kind) begin
            errs++;
            if (errs <= 10)
              $display({"%t mismatch exp x=%0d y=%0d btn=%0d dx=%0d dy=%0d click=%0d kind=%0d",
                        " got x=%0d y=%0d btn=%0d dx=%0d dy=%0d click=%0d kind=%0d"},
                       $realtime, want.pos_x, want.pos_y, want.buttons, want.dlt_x,
                       want.dlt_y, want.click, want.kind, got.pos_x, got.pos_y,
                       got.buttons, got.dlt_x, got.dlt_y, got.click, got.kind);
          end
        end
      end
      if (in_valid && !in_stall) decode_byte(in_rx_byte);
    end
    pending <= reports_due.size();
    err_count <= errs;
  end

endmodule

/* tb/tb_ps2_mouse_packet_tracker_top.sv */
module tb_ps2_mouse_packet_tracker_top;
  import pmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam int LONG_HOLD   = 80;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [7:0]                in_rx_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic [POS_BITS-1:0]       out_pos_x;
  logic [POS_BITS-1:0]       out_pos_y;
  logic [1:0]                out_button_bits;
  logic signed [DELTA_W-1:0] out_delta_x;
  logic signed [DELTA_W-1:0] out_delta_y;
  logic                      out_click;
  logic [1:0]                out_motion_kind;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_wdata;

  int err_count;
  int pending;
  int snd_idle_pct;
  int rcv_stall_pct = 0;
  int hold_req_cnt = 0;
  int holds_done = 0;
  int quiet_cycles = 0;

  ps2_mouse_packet_tracker_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_button_bits (out_button_bits),
    .out_delta_x     (out_delta_x),
    .out_delta_y     (out_delta_y),
    .out_click       (out_click),
    .out_motion_kind (out_motion_kind),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  mouse_report_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_button_bits (out_button_bits),
    .out_delta_x     (out_delta_x),
    .out_delta_y     (out_delta_y),
    .out_click       (out_click),
    .out_motion_kind (out_motion_kind),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .err_count       (err_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random stall, or a long hold-off when one is requested
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_cnt != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_packet(input logic [7:0] h, input logic [7:0] x, input logic [7:0] y);
    send_byte(h);
    send_byte(x);
    send_byte(y);
  endtask

  // stop offering and wait until every predicted report has been seen
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input int lx, input int ly);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_X;
    cfg_wdata <= CFG_W'(lx);
    @(posedge clk);
    cfg_index <= CFG_MAX_Y;
    cfg_wdata <= CFG_W'(ly);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_step(input int drift);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 40) return int'($urandom_range(0, 511)) - 256;
    return drift * int'($urandom_range(100, 255));
  endfunction

  // mostly well-formed packets, some noise and truncated packets
  task automatic send_traffic(input int n_bytes, input int drift);
    int sent;
    int r;
    int dx;
    int dy;
    logic [1:0] btn;
    logic [7:0] h;
    sent = 0;
    while (sent < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 7) begin
        send_byte(8'($urandom_range(0, 255)) & 8'hF7);
        sent += 1;
      end else if (r < 11) begin
        send_byte(8'($urandom_range(0, 255)) | 8'h08);
        send_byte(8'($urandom_range(0, 255)));
        sent += 2;
      end else begin
        dx = pick_step(drift);
        dy = pick_step(drift);
        if (r < 16) begin
          dx = 0;
          dy = 0;
        end
        btn = ($urandom_range(0, 99) < 45) ? 2'b00 : 2'($urandom_range(1, 3));
        h = {2'($urandom_range(0, 3)), dy < 0, dx < 0, 1'b1, 1'($urandom_range(0, 1)), btn};
        send_packet(h, 8'(dx), 8'(dy));
        sent += 3;
      end
    end
  endtask

  initial begin
    int lx;
    int ly;
    int drift;
    in_valid <= 1'b0;
    in_rx_byte <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MAX_X;
    cfg_wdata <= '0;
    snd_idle_pct = 0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: dropped noise, no motion, click, sign extension, clamps
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'h09, 8'h7F, 8'h05);
    send_packet(8'h3A, 8'h00, 8'h00);
    send_packet(8'hCB, 8'hFF, 8'hFF);
    send_packet(8'h08, 8'hFF, 8'hFF);
    set_limits(0, 0);
    send_packet(8'h0C, 8'h10, 8'h10);
    set_limits(8191, 8191);
    send_packet(8'h08, 8'h08, 8'h08);
    send_packet(8'h08, 8'hFF, 8'hFF);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin lx = 8191; ly = 8191; end
        1: begin lx = 37; ly = 5; end
        2: begin lx = 0; ly = 8191; end
        3: begin lx = 1920; ly = 1080; end
        4: begin lx = 8191; ly = 0; end
        default: begin
          lx = $urandom_range(0, 8191);
          ly = $urandom_range(0, 8191);
        end
      endcase
      drift = (ph % 2 == 0) ? 1 : -1;
      set_limits(lx, ly);
      if (ph < 2) begin
        snd_idle_pct = 26;
        rcv_stall_pct <= 76;
      end else if (ph < 4) begin
        snd_idle_pct = 76;
        rcv_stall_pct <= 26;
      end else begin
        snd_idle_pct = 0;
        rcv_stall_pct <= 0;
      end
      if (ph == 4) begin
        send_traffic(120, drift);
        hold_req_cnt <= hold_req_cnt + 1;
        send_traffic(135, drift);
      end else if (ph == 5) begin
        send_traffic(120, drift);
        settle();
        send_traffic(135, drift);
      end else begin
        send_traffic(255, drift);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
